FILE: rtl/ogm_pkg.sv
`default_nettype none
package ogm_pkg;
  localparam int GRID_W = 256;
  localparam int GRID_H = 256;
  localparam int CW = $clog2(GRID_W);
  localparam int RW = $clog2(GRID_H);
  localparam int AW = CW + RW;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_OBST = 3'd1;
  localparam logic [2:0] OP_TERR = 3'd2;
  localparam logic [2:0] OP_FILL = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  localparam logic [1:0] CELL_UNKNOWN = 2'd0;
  localparam logic [1:0] CELL_FREE    = 2'd1;
  localparam logic [1:0] CELL_OCC     = 2'd2;

  localparam logic REG_CELL_SIZE = 1'b0;
  localparam logic REG_CLEAR_RAD = 1'b1;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       status;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [2:0]    op;
    logic          drop;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
  } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/ogm_front.sv
`default_nettype none
module ogm_front import ogm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_item,
  input  wire logic      push,
  output logic           full,
  input  wire logic [9:0] cell_size,
  output cmd_t           cmd,
  output logic           cmd_valid,
  input  wire logic      cmd_ready
);
  // restoring divider: quotient of (2|v|+s)/(2s), one bit a cycle, x then y
  typedef enum logic [1:0] {IDLE, DIV, DONE} st_t;
  st_t st;
  in_item_t item;
  logic axis;
  logic [5:0] cnt;
  logic [17:0] num, quo;
  logic [18:0] rem;
  logic [10:0] dsr;
  logic [17:0] qx;
  logic [9:0] s_eff;
  logic [18:0] rem_sh, rem_sub;
  logic [18:0] num_x, num_y;
  logic signed [19:0] cx, ry;

  assign s_eff = (cell_size == 10'd0) ? 10'd1 : cell_size;
  assign num_x = {2'b0, (item.x_mm < 0) ? 16'(-item.x_mm) : 16'(item.x_mm), 1'b0}
                 + 19'(s_eff);
  assign num_y = {2'b0, (item.y_mm < 0) ? 16'(-item.y_mm) : 16'(item.y_mm), 1'b0}
                 + 19'(s_eff);
  assign rem_sh = {rem[17:0], num[17]};
  assign rem_sub = rem_sh - {8'b0, dsr};

  assign full = rst || (st != IDLE);
  assign cmd_valid = (st == DONE);

  always_comb begin
    cx = (item.x_mm < 0) ? 20'(GRID_W / 2) - 20'(qx) : 20'(GRID_W / 2) + 20'(qx);
    ry = (item.y_mm < 0) ? 20'(GRID_H / 2) - 20'(quo) : 20'(GRID_H / 2) + 20'(quo);
    cmd.op = item.op;
    cmd.drop = 1'b0;
    cmd.col = item.cell_x[CW-1:0];
    cmd.row = item.cell_y[RW-1:0];
    if (item.op == OP_OBST || item.op == OP_TERR) begin
      cmd.drop = (cx < 0) || (cx >= 20'(GRID_W)) || (ry < 0) || (ry >= 20'(GRID_H));
      cmd.col = cx[CW-1:0];
      cmd.row = ry[RW-1:0];
    end else if (item.op == OP_READ) begin
      cmd.drop = (32'(item.cell_x) >= GRID_W) || (32'(item.cell_y) >= GRID_H);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
    end else begin
      case (st)
        IDLE: if (push) begin
          item <= in_item;
          st <= (in_item.op == OP_OBST || in_item.op == OP_TERR) ? DIV : DONE;
          axis <= 1'b0;
          cnt <= 6'd0;
          rem <= '0;
          quo <= '0;
          dsr <= {s_eff, 1'b0};
        end
        DIV: begin
          if (cnt == 6'd0 && !axis) num <= num_x[17:0];
          if (cnt == 6'd0) begin
            if (axis) num <= num_y[17:0];
            rem <= '0;
            quo <= '0;
            cnt <= 6'd1;
          end else begin
            num <= {num[16:0], 1'b0};
            if (!rem_sub[18]) begin
              rem <= rem_sub;
              quo <= {quo[16:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[16:0], 1'b0};
            end
            cnt <= (cnt == 6'd18) ? 6'd0 : cnt + 6'd1;
            if (cnt == 6'd18) begin
              if (!axis) begin
                qx <= rem_sub[18] ? {quo[16:0], 1'b0} : {quo[16:0], 1'b1};
                axis <= 1'b1;
              end else begin
                st <= DONE;
              end
            end
          end
        end
        DONE: if (cmd_ready) st <= IDLE;
        default: st <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ogm_cmd_fifo.sv
`default_nettype none
module ogm_cmd_fifo import ogm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t wr_data,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output cmd_t      rd_data,
  output logic      rd_valid,
  input  wire logic rd_ready
);
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;
  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ogm_back.sv
`default_nettype none
module ogm_back import ogm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [9:0]  cell_size,
  input  wire logic [13:0] clear_rad,
  output out_item_t        res,
  output logic             res_valid,
  input  wire logic        res_ready
);
  typedef enum logic [3:0] {
    IDLE, CLR, INIT_A, INIT_B, INIT_C, RD, RD_W, OBS, OBS_W, TER, FILL_RD, FILL_W,
    FILL_DEC, OUT
  } st_t;
  st_t st;
  cmd_t c;
  logic [1:0] grid [GRID_W*GRID_H];
  logic [1:0] rdata;
  logic [AW-1:0] raddr;
  logic re;
  logic [AW-1:0] waddr;
  logic [1:0] wdata;
  logic we;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [3:0] k;
  logic [3:0] nfree;
  logic [9:0] s_eff;
  logic [19:0] s2;
  logic [29:0] rr4;
  logic [20:0] d2;
  logic [40:0] prod;
  logic signed [CW+1:0] dx;
  logic signed [RW+1:0] dy;
  logic signed [CW+1:0] nc;
  logic signed [RW+1:0] nr;
  logic signed [CW+1:0] dcol;
  logic signed [RW+1:0] drow;
  logic inner;

  assign s_eff = (cell_size == 10'd0) ? 10'd1 : cell_size;
  assign cmd_ready = (st == IDLE);
  assign res_valid = (st == OUT);
  assign inner = (col != '0) && (32'(col) != GRID_W - 1) && (row != '0)
                 && (32'(row) != GRID_H - 1);
  assign dx = $signed({1'b0, col, 1'b0}) - (CW+2)'(GRID_W);
  assign dy = $signed({1'b0, row, 1'b0}) - (RW+2)'(GRID_H);
  assign nc = $signed({2'b0, col}) + dcol;
  assign nr = $signed({2'b0, row}) + drow;

  // neighbor offsets, k walks the 3x3 block row by row
  always_comb begin
    if (k inside {4'd0, 4'd3, 4'd6}) dcol = '1;
    else if (k inside {4'd2, 4'd5, 4'd8}) dcol = (CW+2)'(1);
    else dcol = '0;
    if (k < 4'd3) drow = '1;
    else if (k < 4'd6) drow = '0;
    else drow = (RW+2)'(1);
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= grid[raddr];
    if (we) grid[waddr] <= wdata;
  end

  always_comb begin
    re = 1'b0;
    raddr = {row, col};
    we = 1'b0;
    waddr = {row, col};
    wdata = CELL_UNKNOWN;
    case (st)
      CLR: begin
        we = 1'b1;
      end
      INIT_C: begin
        we = 1'b1;
        wdata = (prod < 41'(rr4)) ? CELL_FREE : CELL_UNKNOWN;
      end
      RD: re = 1'b1;
      OBS: begin
        we = 1'b1;
        wdata = CELL_OCC;
        waddr = {nr[RW-1:0], nc[CW-1:0]};
      end
      TER: begin
        we = (rdata == CELL_UNKNOWN);
        wdata = CELL_FREE;
      end
      FILL_RD: begin
        re = 1'b1;
        raddr = {nr[RW-1:0], nc[CW-1:0]};
      end
      FILL_DEC: begin
        we = (nfree >= 4'd5);
        wdata = CELL_FREE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= CLR;
      row <= '0;
      col <= '0;
    end else begin
      case (st)
        CLR: begin
          col <= col + 1'b1;
          if (&col) begin
            row <= row + 1'b1;
            if (&row) st <= IDLE;
          end
        end
        IDLE: if (cmd_valid) begin
          c <= cmd;
          res <= '{cell_state: CELL_UNKNOWN, status: cmd.drop};
          s2 <= 20'(s_eff) * 20'(s_eff);
          rr4 <= 30'(clear_rad) * 30'(clear_rad) * 30'd4;
          k <= 4'd4;
          nfree <= 4'd0;
          if (cmd.drop) begin
            col <= cmd.col;
            row <= cmd.row;
            st <= OUT;
          end else begin
            case (cmd.op)
              OP_INIT: begin col <= '0; row <= '0; st <= INIT_A; end
              OP_OBST, OP_TERR, OP_READ: begin
                col <= cmd.col;
                row <= cmd.row;
                st <= RD;
              end
              OP_FILL: begin col <= CW'(1); row <= RW'(1); st <= FILL_RD; end
              default: begin col <= cmd.col; row <= cmd.row; st <= OUT; end
            endcase
          end
        end
        INIT_A: begin
          d2 <= 21'(dx * dx) + 21'(dy * dy);
          st <= INIT_B;
        end
        INIT_B: st <= INIT_C;
        INIT_C: begin
          col <= col + 1'b1;
          if (&col) row <= row + 1'b1;
          st <= (&col && &row) ? OUT : INIT_A;
        end
        RD: st <= RD_W;
        RD_W: begin
          if (c.op == OP_READ) begin res.cell_state <= rdata; st <= OUT; end
          else if (c.op == OP_TERR) st <= TER;
          else if (rdata == CELL_OCC) st <= OUT;
          else begin k <= inner ? 4'd0 : 4'd4; st <= OBS; end
        end
        OBS: begin
          if (!inner || k == 4'd8) st <= OUT;
          else k <= k + 4'd1;
        end
        TER: st <= OUT;
        FILL_RD: begin
          st <= FILL_W;
        end
        FILL_W: begin
          if (k == 4'd4) begin
            if (rdata != CELL_UNKNOWN) begin
              k <= 4'd0; nfree <= 4'd0;
              st <= FILL_DEC;
            end else begin k <= 4'd0; st <= FILL_RD; end
          end else begin
            if (rdata == CELL_FREE) nfree <= nfree + 4'd1;
            if (k == 4'd8) begin k <= 4'd9; st <= FILL_DEC; end
            else if (k == 4'd3) begin k <= 4'd5; st <= FILL_RD; end
            else begin k <= k + 4'd1; st <= FILL_RD; end
          end
        end
        FILL_DEC: begin
          k <= 4'd4;
          nfree <= 4'd0;
          if (32'(row) == GRID_H - 2) begin
            row <= RW'(1);
            if (32'(col) == GRID_W - 2) st <= OUT;
            else begin col <= col + 1'b1; st <= FILL_RD; end
          end else begin
            row <= row + 1'b1;
            st <= FILL_RD;
          end
        end
        OUT: if (res_ready) st <= IDLE;
        default: st <= IDLE;
      endcase
    end
  end

  // product of squared distance and squared size, registered for INIT_C
  always_ff @(posedge clk) begin
    if (st == INIT_B) prod <= 41'(d2) * 41'(s2);
  end

`ifndef NO_ASSERTIONS
  a_no_wr_idle: assert property (@(posedge clk) disable iff (rst)
    st == IDLE |-> !we) else $error("write while idle");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result lost");
  a_take: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready) else $error("double take");
`endif
endmodule
`default_nettype wire

FILE: rtl/occupancy_grid_marker.sv
`default_nettype none
// channel | handshake   | payload
// in      | push / full | in_item  (op, x_mm, y_mm, cell_x, cell_y)
// out     | empty / pop | out_item (cell_state, status)
// cfg     | cfg_we      | cfg_index, cfg_data
// A point passes the front in two 18-bit serial divisions and then the back,
// which marks cells one a cycle, one grid access at a time.
// Init sweep: INIT_A, INIT_B, INIT_C per cell; fill sweep: interior cells only.
// After rst the back clears the 65536-cell grid, one cell a cycle, before
// taking commands. A two-entry command queue parts front and back.
module occupancy_grid_marker import ogm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_item,
  input  wire logic      push,
  output logic           full,
  output out_item_t      out_item,
  output logic           empty,
  input  wire logic      pop,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [13:0] cfg_data
);
  logic [9:0] cell_size;
  logic [13:0] clear_rad;
  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready, r_valid;

  // hold register values
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= 10'd50;
      clear_rad <= 14'd400;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_SIZE: cell_size <= cfg_data[9:0];
        REG_CLEAR_RAD: clear_rad <= cfg_data;
        default: ;
      endcase
    end
  end

  ogm_front u_front (.clk, .rst, .in_item, .push, .full, .cell_size,
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready));
  ogm_cmd_fifo u_q (.clk, .rst, .wr_data(f_cmd), .wr_valid(f_valid),
    .wr_ready(f_ready), .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready));
  ogm_back u_back (.clk, .rst, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .cell_size, .clear_rad, .res(out_item), .res_valid(r_valid), .res_ready(pop));
  assign empty = !r_valid;
endmodule
`default_nettype wire
